### sv/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and constants for the machine trap and timer unit.
// ----------------------------------------------------------------------------
package mtt_pkg;

    // widths
    localparam int TIMER_WIDTH   = 64;
    localparam int COMPARE_WIDTH = 64;
    localparam int XLEN          = 32;

    // cause encoding
    localparam logic [XLEN-1:0] CAUSE_IRQ_BIT   = 32'h8000_0000;
    localparam logic [XLEN-1:0] CAUSE_CODE_MASK = 32'h7fff_ffff;
    localparam logic [XLEN-1:0] TIMER_IRQ_CAUSE = 32'h8000_0007;

    // item kinds
    typedef enum logic [1:0] {
        MODE_TICK       = 2'd0,
        MODE_TRAP       = 2'd1,
        MODE_WR_COMPARE = 2'd2,
        MODE_WR_ENABLE  = 2'd3
    } t_mode;

    // privilege levels
    typedef enum logic [1:0] {
        PRIV_USER       = 2'd0,
        PRIV_SUPERVISOR = 2'd1,
        PRIV_RESERVED   = 2'd2,
        PRIV_MACHINE    = 2'd3
    } t_priv;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_VECTOR_BASE      = 2'd0,
        CFG_VECTOR_MODE      = 2'd1,
        CFG_TIMER_IRQ_ENABLE = 2'd2,
        CFG_UNUSED           = 2'd3
    } t_cfg_index;

    // configuration register contents
    typedef struct packed {
        logic [XLEN-1:0] vector_base;
        logic            vector_mode;
        logic            timer_irq_enable;
    } t_cfg;

    // input item
    typedef struct packed {
        logic [1:0]               mode;
        logic [XLEN-1:0]          trap_cause;
        logic [XLEN-1:0]          trap_value;
        logic [XLEN-1:0]          current_pc;
        logic [1:0]               privilege;
        logic [COMPARE_WIDTH-1:0] new_compare;
        logic                     enable_value;
    } t_in_item;

    // result item
    typedef struct packed {
        logic            trap_taken;
        logic [XLEN-1:0] target_pc;
        logic [XLEN-1:0] saved_pc_out;
        logic [XLEN-1:0] saved_cause_out;
        logic [XLEN-1:0] saved_value_out;
        logic            global_enable_out;
        logic            prior_enable_out;
        logic [1:0]      prior_privilege_out;
        logic            level_error;
    } t_out_item;

endpackage

### sv/mtt_trap_core.sv
// ----------------------------------------------------------------------------
// mtt_trap_core
// Architectural state (timer, compare, enables, saved trap info) and the
// update that one item applies to it.
// ----------------------------------------------------------------------------
module mtt_trap_core
    import mtt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [TIMER_WIDTH-1:0]   r_time_count,    n_time_count;
    logic [COMPARE_WIDTH-1:0] r_compare_value, n_compare_value;
    logic                     r_compare_armed, n_compare_armed;
    logic                     r_global_enable, n_global_enable;
    logic                     r_prior_enable,  n_prior_enable;
    logic [1:0]               r_prior_priv,    n_prior_priv;
    logic [XLEN-1:0]          r_saved_pc,      n_saved_pc;
    logic [XLEN-1:0]          r_saved_cause,   n_saved_cause;
    logic [XLEN-1:0]          r_saved_value,   n_saved_value;

    logic [TIMER_WIDTH-1:0]   count_inc;
    logic [COMPARE_WIDTH-1:0] count_ext;
    logic                     timer_hit;
    logic                     is_tick;
    logic                     want_trap;
    logic [XLEN-1:0]          cause;
    logic [XLEN-1:0]          value;
    logic                     is_irq;
    logic                     do_save;
    logic                     reserved_level;
    logic                     taken;
    logic                     level_err;
    logic [XLEN-1:0]          target;

    // timer increment and compare
    assign count_inc = r_time_count + TIMER_WIDTH'(1);
    assign count_ext = COMPARE_WIDTH'(count_inc);
    assign timer_hit = r_compare_armed && (count_ext >= r_compare_value) &&
                       r_global_enable && i_cfg.timer_irq_enable;

    // trap decision
    assign is_tick        = (i_item.mode == MODE_TICK);
    assign want_trap      = (i_item.mode == MODE_TRAP) || (is_tick && timer_hit);
    assign cause          = is_tick ? TIMER_IRQ_CAUSE : i_item.trap_cause;
    assign value          = is_tick ? '0 : i_item.trap_value;
    assign is_irq         = |(cause & CAUSE_IRQ_BIT);
    assign do_save        = want_trap && !(is_irq && !r_global_enable);
    assign reserved_level = (i_item.privilege == PRIV_RESERVED);
    assign taken          = do_save && !reserved_level;
    assign level_err      = do_save && reserved_level;

    // handler address, only interrupts are vectored
    always_comb begin
        if (i_cfg.vector_mode && is_irq) begin
            target = i_cfg.vector_base + {cause[XLEN-3:0], 2'b00};
        end else begin
            target = i_cfg.vector_base;
        end
    end

    // next state
    always_comb begin
        n_time_count    = r_time_count;
        n_compare_value = r_compare_value;
        n_compare_armed = r_compare_armed;
        n_global_enable = r_global_enable;
        n_prior_enable  = r_prior_enable;
        n_prior_priv    = r_prior_priv;
        n_saved_pc      = r_saved_pc;
        n_saved_cause   = r_saved_cause;
        n_saved_value   = r_saved_value;
        case (i_item.mode)
            MODE_TICK: begin
                n_time_count = count_inc;
            end
            MODE_WR_COMPARE: begin
                n_compare_value = i_item.new_compare;
                n_compare_armed = 1'b1;
            end
            MODE_WR_ENABLE: begin
                n_global_enable = i_item.enable_value;
            end
            default: begin
            end
        endcase
        if (do_save) begin
            n_saved_pc    = i_item.current_pc;
            n_saved_cause = cause;
            n_saved_value = value;
        end
        if (taken) begin
            n_prior_priv    = i_item.privilege;
            n_prior_enable  = r_global_enable;
            n_global_enable = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_count    <= '0;
            r_compare_value <= '0;
            r_compare_armed <= 1'b0;
            r_global_enable <= 1'b0;
            r_prior_enable  <= 1'b0;
            r_prior_priv    <= '0;
            r_saved_pc      <= '0;
            r_saved_cause   <= '0;
            r_saved_value   <= '0;
        end else if (i_fire) begin
            r_time_count    <= n_time_count;
            r_compare_value <= n_compare_value;
            r_compare_armed <= n_compare_armed;
            r_global_enable <= n_global_enable;
            r_prior_enable  <= n_prior_enable;
            r_prior_priv    <= n_prior_priv;
            r_saved_pc      <= n_saved_pc;
            r_saved_cause   <= n_saved_cause;
            r_saved_value   <= n_saved_value;
        end
    end

    // result reflects the state after this item
    always_comb begin
        o_result.trap_taken          = taken;
        o_result.target_pc           = taken ? target : '0;
        o_result.saved_pc_out        = n_saved_pc;
        o_result.saved_cause_out     = n_saved_cause;
        o_result.saved_value_out     = n_saved_value;
        o_result.global_enable_out   = n_global_enable;
        o_result.prior_enable_out    = n_prior_enable;
        o_result.prior_privilege_out = n_prior_priv;
        o_result.level_error         = level_err;
    end

endmodule

### sv/machine_trap_and_timer_unit.sv
// ----------------------------------------------------------------------------
// machine_trap_and_timer_unit
// Machine-mode trap entry with a tick timer and compare interrupt.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one item per
//   transfer: a timer tick, a trap request, a compare write or a global
//   enable write. Each item yields exactly one result on the output channel
//   (o_out_valid / i_out_stall / o_out_item).
//   An item passes through the input register, then through the state
//   update and the result register. Throughput is one item per cycle
//   while the receiver does not stall; the timer increment and the 64-bit
//   compare against the compare value set the path through the update.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more item; further items stall until
//   the result is taken.
//   Configuration writes (i_cfg_valid / o_cfg_ready) are always accepted
//   and take effect on the next cycle; index 3 is ignored.
//   Synchronous reset clears all timer, enable, saved trap state and
//   configuration to zero and empties both registers.
// ----------------------------------------------------------------------------
module machine_trap_and_timer_unit
    import mtt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    // configuration channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [XLEN-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_cfg      r_cfg;
    t_out_item result;
    logic      out_free;
    logic      advance;
    logic      in_xfer;

    // handshake control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_VECTOR_BASE:      r_cfg.vector_base      <= i_cfg_data;
                CFG_VECTOR_MODE:      r_cfg.vector_mode      <= i_cfg_data[0];
                CFG_TIMER_IRQ_ENABLE: r_cfg.timer_irq_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_in_item;
        end
    end

    // state update
    mtt_trap_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### sv/mtt_checker.sv
// ----------------------------------------------------------------------------
// mtt_checker
// Port-level checks for the machine trap and timer unit, bound to the top.
// ----------------------------------------------------------------------------
module mtt_checker
    import mtt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // a taken trap and a level error never come together
    a_taken_xor_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.trap_taken && o_out_item.level_error))
        else $error("trap taken with level error");

    // trap entry clears the global enable
    a_taken_clears_ie: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.trap_taken |-> !o_out_item.global_enable_out)
        else $error("global enable set after trap entry");

    // no handler address without a trap, never a reserved previous level
    a_target_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.trap_taken |->
            o_out_item.target_pc == '0 &&
            o_out_item.prior_privilege_out != PRIV_RESERVED)
        else $error("target or previous level wrong without a trap");

endmodule

bind machine_trap_and_timer_unit mtt_checker u_mtt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the machine trap and timer unit. A local model of
// the timer, enable bits and saved trap state predicts one result per input
// transfer; each result transfer is compared field by field with the oldest
// prediction. Directed trap, timer and configuration cases come first, then
// random traffic under changing sender and receiver idling, then a long
// receiver hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
    import mtt_pkg::*;

    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    logic            o_in_stall;
    t_in_item        i_in_item   = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    t_out_item       o_out_item;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [1:0]      i_cfg_index = CFG_VECTOR_BASE;
    logic [XLEN-1:0] i_cfg_data  = '0;

    // bench control
    int errors         = 0;
    int send_idle_pct  = 37;
    int recv_stall_pct = 70;
    int hold_request   = 0;
    int hold_left      = 0;

    // predicted results waiting for their transfer
    t_out_item pending_results[$];

    // model state of the trap unit
    logic [TIMER_WIDTH-1:0]   tick_count   = '0;
    logic [COMPARE_WIDTH-1:0] compare_reg  = '0;
    logic                     armed        = 1'b0;
    logic                     irq_en       = 1'b0;
    logic                     prev_irq_en  = 1'b0;
    logic [1:0]               prev_priv    = '0;
    logic [XLEN-1:0]          epc          = '0;
    logic [XLEN-1:0]          ecause       = '0;
    logic [XLEN-1:0]          evalue       = '0;
    logic [XLEN-1:0]          cfg_base     = '0;
    logic                     cfg_vectored = 1'b0;
    logic                     cfg_timer_en = 1'b0;

    machine_trap_and_timer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one item to the model state and build the result it causes
    function automatic t_out_item apply_item(input t_in_item it);
        t_out_item       res;
        logic            want_trap;
        logic            is_irq;
        logic [XLEN-1:0] cause;
        logic [XLEN-1:0] tval;
        res       = '0;
        want_trap = 1'b0;
        cause     = it.trap_cause;
        tval      = it.trap_value;
        case (it.mode)
            MODE_TICK: begin
                tick_count = tick_count + 1'b1;
                if (armed && tick_count >= compare_reg && irq_en && cfg_timer_en) begin
                    want_trap = 1'b1;
                    cause     = TIMER_IRQ_CAUSE;
                    tval      = '0;
                end
            end
            MODE_TRAP: want_trap = 1'b1;
            MODE_WR_COMPARE: begin
                compare_reg = it.new_compare;
                armed       = 1'b1;
            end
            default: irq_en = it.enable_value;
        endcase
        // interrupts are dropped while globally disabled
        is_irq = (cause & CAUSE_IRQ_BIT) != '0;
        if (want_trap && !(is_irq && !irq_en)) begin
            ecause = cause;
            evalue = tval;
            epc    = it.current_pc;
            if (it.privilege == PRIV_RESERVED) begin
                res.level_error = 1'b1;
            end else begin
                prev_priv     = it.privilege;
                prev_irq_en   = irq_en;
                irq_en        = 1'b0;
                res.trap_taken = 1'b1;
                if (cfg_vectored && is_irq)
                    res.target_pc = cfg_base + ((cause & CAUSE_CODE_MASK) << 2);
                else
                    res.target_pc = cfg_base;
            end
        end
        res.saved_pc_out        = epc;
        res.saved_cause_out     = ecause;
        res.saved_value_out     = evalue;
        res.global_enable_out   = irq_en;
        res.prior_enable_out    = prev_irq_en;
        res.prior_privilege_out = prev_priv;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns mismatch %s: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic compare_result(input t_out_item want, input t_out_item got);
        check_field("trap_taken", want.trap_taken, got.trap_taken);
        check_field("target_pc", want.target_pc, got.target_pc);
        check_field("saved_pc_out", want.saved_pc_out, got.saved_pc_out);
        check_field("saved_cause_out", want.saved_cause_out, got.saved_cause_out);
        check_field("saved_value_out", want.saved_value_out, got.saved_value_out);
        check_field("global_enable_out", want.global_enable_out, got.global_enable_out);
        check_field("prior_enable_out", want.prior_enable_out, got.prior_enable_out);
        check_field("prior_privilege_out", want.prior_privilege_out,
                    got.prior_privilege_out);
        check_field("level_error", want.level_error, got.level_error);
    endtask

    // result checking and receiver stall, including the long hold-off
    always @(posedge i_clk) begin : result_side
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t ns mismatch: expected no result, actual %h", $time,
                         o_out_item);
            end else begin
                want = pending_results.pop_front();
                compare_result(want, o_out_item);
            end
        end
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // one input transfer; the prediction is made when it is accepted
    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(apply_item(it));
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        it.mode         = 2'($urandom_range(0, 3));
        it.trap_cause   = $urandom;
        it.trap_value   = $urandom;
        it.current_pc   = $urandom;
        it.privilege    = 2'($urandom_range(0, 3));
        it.new_compare  = {$urandom, $urandom};
        it.enable_value = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_tick(input logic [XLEN-1:0] pc, input t_priv priv);
        t_in_item it;
        it            = random_item();
        it.mode       = MODE_TICK;
        it.current_pc = pc;
        it.privilege  = priv;
        send_item(it);
    endtask

    task automatic send_trap(input logic [XLEN-1:0] cause, input logic [XLEN-1:0] tval,
                             input logic [XLEN-1:0] pc, input t_priv priv);
        t_in_item it;
        it            = random_item();
        it.mode       = MODE_TRAP;
        it.trap_cause = cause;
        it.trap_value = tval;
        it.current_pc = pc;
        it.privilege  = priv;
        send_item(it);
    endtask

    task automatic send_compare(input logic [COMPARE_WIDTH-1:0] cmp);
        t_in_item it;
        it             = random_item();
        it.mode        = MODE_WR_COMPARE;
        it.new_compare = cmp;
        send_item(it);
    endtask

    task automatic send_enable(input logic en);
        t_in_item it;
        it              = random_item();
        it.mode         = MODE_WR_ENABLE;
        it.enable_value = en;
        send_item(it);
    endtask

    // drop the input valid and let every pending result drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_index idx, input logic [XLEN-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_VECTOR_BASE:      cfg_base     = data;
            CFG_VECTOR_MODE:      cfg_vectored = data[0];
            CFG_TIMER_IRQ_ENABLE: cfg_timer_en = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic randomize_config();
        logic [XLEN-1:0] base;
        case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = '1;
            default: base = $urandom;
        endcase
        cfg_write(CFG_VECTOR_BASE, base);
        cfg_write(CFG_VECTOR_MODE, $urandom);
        if ($urandom_range(0, 99) < 80)
            cfg_write(CFG_TIMER_IRQ_ENABLE, $urandom | 32'h1);
        else
            cfg_write(CFG_TIMER_IRQ_ENABLE, $urandom & ~32'h1);
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_UNUSED, $urandom);
    endtask

    // weighted mix; compare writes mostly land just ahead of the count
    task automatic send_random_item();
        int                       pick;
        logic [XLEN-1:0]          cause;
        logic [COMPARE_WIDTH-1:0] cmp;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            send_item(random_item());
        end else if (pick < 45) begin
            send_tick($urandom, t_priv'($urandom_range(0, 3)));
        end else if (pick < 68) begin
            case ($urandom_range(0, 3))
                0, 1:    cause = CAUSE_IRQ_BIT | $urandom_range(0, 15);
                2:       cause = $urandom_range(0, 15);
                default: cause = $urandom;
            endcase
            send_trap(cause, $urandom, $urandom, t_priv'($urandom_range(0, 3)));
        end else if (pick < 78) begin
            case ($urandom_range(0, 9))
                0:       cmp = '0;
                1:       cmp = '1;
                2:       cmp = {$urandom, $urandom};
                default: cmp = tick_count + $urandom_range(0, 12);
            endcase
            send_compare(cmp);
        end else begin
            send_enable($urandom_range(0, 99) < 80);
        end
    endtask

    // outputs right after reset, timer not armed
    task automatic test_reset_state();
        send_tick($urandom, t_priv'($urandom_range(0, 3)));
    endtask

    // exceptions, interrupts, vectoring and the reserved level
    task automatic test_trap_entry();
        wait_idle();
        cfg_write(CFG_VECTOR_BASE, 32'h8000_0000);
        cfg_write(CFG_VECTOR_MODE, 32'h1);
        cfg_write(CFG_TIMER_IRQ_ENABLE, 32'h1);
        cfg_write(CFG_UNUSED, 32'hffff_ffff);
        // exception is taken even with interrupts disabled
        send_trap(32'h0000_0002, 32'hffff_ffff, 32'h0000_0000, PRIV_USER);
        // interrupt while disabled is dropped
        send_trap(32'h8000_000b, 32'h1234_5678, 32'h0000_1000, PRIV_MACHINE);
        send_enable(1'b1);
        send_trap(32'h8000_000b, 32'h0000_0000, 32'hffff_ffff, PRIV_SUPERVISOR);
        send_enable(1'b1);
        // largest code wraps the vectored target
        send_trap(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, PRIV_MACHINE);
        send_enable(1'b1);
        send_trap(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, PRIV_RESERVED);
        // exceptions are never vectored
        send_trap(32'h7fff_ffff, 32'haaaa_5555, 32'h5555_aaaa, PRIV_MACHINE);
    endtask

    // compare hit, re-fire while still armed, no hit at max, reserved level
    task automatic test_timer_interrupt();
        send_enable(1'b1);
        send_compare('0);
        send_tick(32'h0000_0040, PRIV_MACHINE);
        send_tick(32'h0000_0044, PRIV_MACHINE);
        send_enable(1'b1);
        send_tick(32'h0000_0048, PRIV_USER);
        send_enable(1'b1);
        send_compare('1);
        send_tick(32'h0000_004c, PRIV_MACHINE);
        send_compare(tick_count + 3);
        repeat (3) send_tick($urandom, PRIV_SUPERVISOR);
        send_enable(1'b1);
        send_compare('0);
        send_tick(32'hdead_beef, PRIV_RESERVED);
        send_enable(1'b0);
    endtask

    // extreme register values, timer interrupt disabled in direct mode, then vectored mode
    task automatic test_config_extremes();
        wait_idle();
        cfg_write(CFG_VECTOR_BASE, 32'hffff_ffff);
        cfg_write(CFG_VECTOR_MODE, 32'hffff_fffe);
        cfg_write(CFG_TIMER_IRQ_ENABLE, 32'h0);
        send_enable(1'b1);
        send_tick(32'h0000_0100, PRIV_MACHINE);
        send_trap(32'h8000_0003, 32'h0000_0001, 32'h0000_0104, PRIV_MACHINE);
        wait_idle();
        cfg_write(CFG_VECTOR_BASE, 32'h0000_0000);
        cfg_write(CFG_VECTOR_MODE, 32'h0000_0001);
        cfg_write(CFG_TIMER_IRQ_ENABLE, 32'hffff_ffff);
        send_enable(1'b1);
        send_trap(32'h8000_0001, 32'h0000_0000, 32'h0000_0200, PRIV_USER);
    endtask

    // random traffic, reconfigured every 200 items
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 200 == 0) begin
                wait_idle();
                randomize_config();
            end
            send_random_item();
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = HOLD_CYCLES;
        repeat (60) send_random_item();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_trap_entry();
        test_timer_interrupt();
        test_config_extremes();
        test_random_traffic(37, 70, 650);
        test_random_traffic(70, 37, 650);
        test_random_traffic(0, 0, 650);
        test_backpressure();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial begin
        #RUN_LIMIT_NS;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
sv/mtt_pkg.sv
sv/mtt_trap_core.sv
sv/machine_trap_and_timer_unit.sv
sv/mtt_checker.sv
sim/tb_top.sv
